// ===== design/bf33_pkg.sv =====
// Package for the 3x3 mean filter: field widths, register indexes, reset values,
// and the divide-by-nine reciprocal. It has no dependencies.
`timescale 1ns / 1ps

package bf33_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 4096;

  localparam int PIX_W        = 8;
  localparam int ROW_W        = 12;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_W        = 13;
  localparam int CFG_IDX_W    = 1;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd512;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd512;

  // Nine pixels of at most 255 sum to at most 2295.
  localparam int                SUM_W       = 12;
  localparam logic [SUM_W-1:0]  SUM_MAX     = 12'd2295;
  localparam int                RECIP_W     = 13;
  localparam int                RECIP_SHIFT = 16;
  localparam logic [RECIP_W-1:0] RECIP9     = 13'd7282;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic             last;
    logic             interior;
  } pos_t;

endpackage

// ===== design/box_filter_3x3_mean.sv =====
// Top level of the 3x3 mean filter: handshake, pipeline valids and the pipeline stages.
// Depends on bf33_pkg, bf33_pos_ctrl, bf33_line_store, bf33_window_sum and bf33_div9.
//
//   Port group   Direction  Transfer content
//   s_*          in         one pixel, raster order
//   m_*          out        mean, centre column, centre row; tlast ends the frame
//   cfg_*        in         frame_width (index 0), frame_height (index 1)
//
// One pixel is taken every cycle while s_tready is high. A result passes the line read,
// window sum and divide registers once the pixel below-right of its centre is taken.
// Reset clears the counters, window and pipeline and sets both sizes to 512; the line
// stores need no clearing pass. A held m_tready fills the pipeline stage by stage
// before s_tready drops. A configuration write restarts the frame at column 0, row 0.
`timescale 1ns / 1ps

module box_filter_3x3_mean #(
  parameter int MAX_WIDTH = bf33_pkg::MAX_WIDTH_DEF,
  parameter int COL_W     = $clog2(MAX_WIDTH),
  parameter int OUT_W     = bf33_pkg::PIX_W + COL_W + bf33_pkg::ROW_W,
  parameter int TDATA_W   = ((OUT_W + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [bf33_pkg::PIX_W-1:0]      s_tdata,   // pixel_in
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [TDATA_W-1:0]              m_tdata,   // mean_value, centre_column, centre_row
  output logic                            m_tlast,   // frame_last
  input  logic                            cfg_we,
  input  logic [bf33_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bf33_pkg::CFG_W-1:0]      cfg_data
);
  import bf33_pkg::*;

  logic             v1, v2, v3;
  logic             ready1, ready2, ready3;
  logic             acc, adv1, adv2;
  logic [COL_W-1:0] cur_col;
  pos_t             cur_pos;
  logic [PIX_W-1:0] px1;
  logic [COL_W-1:0] col1;
  pos_t             pos1;
  logic [PIX_W-1:0] top_q, mid_q;
  logic [SUM_W-1:0] sum2;
  logic [COL_W-1:0] col2;
  pos_t             pos2;
  logic [PIX_W-1:0] out_mean;
  logic [COL_W-1:0] out_col;
  logic [ROW_W-1:0] out_row;

  assign ready3   = !v3 || m_tready;
  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign s_tready = ready1;
  assign acc      = s_tvalid && ready1;
  assign adv1     = v1 && ready2;
  assign adv2     = v2 && ready3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ready1) begin
        v1 <= acc;
      end
      if (ready2) begin
        v2 <= adv1 && pos1.interior;
      end
      if (ready3) begin
        v3 <= adv2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      px1  <= s_tdata;
      col1 <= cur_col;
      pos1 <= cur_pos;
    end
  end

  bf33_pos_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .COL_W     (COL_W)
  ) u_pos (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (acc),
    .col       (cur_col),
    .pos       (cur_pos)
  );

  bf33_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (COL_W)
  ) u_lines (
    .clk     (clk),
    .rd_en   (acc),
    .rd_addr (cur_col),
    .wr_en   (adv1),
    .wr_addr (col1),
    .wr_px   (px1),
    .top_q   (top_q),
    .mid_q   (mid_q)
  );

  bf33_window_sum #(
    .COL_W (COL_W)
  ) u_win (
    .clk      (clk),
    .rst      (rst),
    .shift_en (adv1),
    .top      (top_q),
    .mid      (mid_q),
    .px       (px1),
    .col      (col1),
    .pos      (pos1),
    .sum_q    (sum2),
    .col_q    (col2),
    .pos_q    (pos2)
  );

  bf33_div9 #(
    .COL_W (COL_W)
  ) u_div (
    .clk           (clk),
    .load          (adv2),
    .sum           (sum2),
    .col           (col2),
    .pos           (pos2),
    .mean_value    (out_mean),
    .centre_column (out_col),
    .centre_row    (out_row),
    .frame_last    (m_tlast)
  );

  assign m_tvalid = v3;
  assign m_tdata  = TDATA_W'({out_row, out_col, out_mean});

`ifndef ASSERT_OFF
  a_centre_interior: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_col != '0) && (out_row != '0))
    else $error("result centre lies on the frame border");

  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> (cur_col == '0) && (cur_pos.row == '0))
    else $error("configuration write did not restart the frame");

  a_sum_range: assert property (@(posedge clk) disable iff (rst)
    v2 |-> (sum2 <= SUM_MAX))
    else $error("window sum out of range");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    acc |=> v1)
    else $error("accepted pixel missing from the first stage");
`endif

endmodule

// ===== design/bf33_pos_ctrl.sv =====
// Frame size registers and the column and row counters of the incoming pixel.
// Depends on bf33_pkg.
`timescale 1ns / 1ps

module bf33_pos_ctrl #(
  parameter int MAX_WIDTH = bf33_pkg::MAX_WIDTH_DEF,
  parameter int COL_W     = $clog2(MAX_WIDTH)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [bf33_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bf33_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            advance,
  output logic [COL_W-1:0]                col,
  output bf33_pkg::pos_t                  pos
);
  import bf33_pkg::*;

  logic [WIDTH_REG_W-1:0]  frame_width;
  logic [HEIGHT_REG_W-1:0] frame_height;
  logic [ROW_W-1:0]        row;
  logic [COL_W-1:0]        w_m1;
  logic [ROW_W-1:0]        h_m1;
  logic                    col_end;
  logic                    row_end;

  always_comb begin
    if (frame_width < 11'd3) begin
      w_m1 = COL_W'(2);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      w_m1 = COL_W'(MAX_WIDTH - 1);
    end else begin
      w_m1 = COL_W'(frame_width - 11'd1);
    end
    if (frame_height < 13'd3) begin
      h_m1 = ROW_W'(2);
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      h_m1 = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      h_m1 = ROW_W'(frame_height - 13'd1);
    end
  end

  assign col_end = (col == w_m1);
  assign row_end = (row == h_m1);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
      col          <= '0;
      row          <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[WIDTH_REG_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[HEIGHT_REG_W-1:0];
        default: ;
      endcase
      col <= '0;
      row <= '0;
    end else if (advance) begin
      if (col_end) begin
        col <= '0;
        row <= row_end ? '0 : row + ROW_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  assign pos.row      = row;
  assign pos.last     = col_end && row_end;
  assign pos.interior = (col >= COL_W'(2)) && (row >= ROW_W'(2));

endmodule

// ===== design/bf33_line_store.sv =====
// Two line memories holding the two rows above the incoming pixel, with registered reads.
// Depends on bf33_pkg.
`timescale 1ns / 1ps

module bf33_line_store #(
  parameter int DEPTH = bf33_pkg::MAX_WIDTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [bf33_pkg::PIX_W-1:0]  wr_px,
  output logic [bf33_pkg::PIX_W-1:0]  top_q,
  output logic [bf33_pkg::PIX_W-1:0]  mid_q
);
  import bf33_pkg::*;

  logic [PIX_W-1:0] upper_mem [DEPTH];
  logic [PIX_W-1:0] middle_mem [DEPTH];

  // The middle row moves up into the upper store as the new pixel takes its place.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr]  <= mid_q;
      middle_mem[wr_addr] <= wr_px;
    end
    if (rd_en) begin
      top_q <= upper_mem[rd_addr];
      mid_q <= middle_mem[rd_addr];
    end
  end

endmodule

// ===== design/bf33_window_sum.sv =====
// The six window registers of the two previous columns and the registered nine-pixel sum.
// Depends on bf33_pkg.
`timescale 1ns / 1ps

module bf33_window_sum #(
  parameter int COL_W = $clog2(bf33_pkg::MAX_WIDTH_DEF)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        shift_en,
  input  logic [bf33_pkg::PIX_W-1:0]  top,
  input  logic [bf33_pkg::PIX_W-1:0]  mid,
  input  logic [bf33_pkg::PIX_W-1:0]  px,
  input  logic [COL_W-1:0]            col,
  input  bf33_pkg::pos_t              pos,
  output logic [bf33_pkg::SUM_W-1:0]  sum_q,
  output logic [COL_W-1:0]            col_q,
  output bf33_pkg::pos_t              pos_q
);
  import bf33_pkg::*;

  logic [PIX_W-1:0] win [6];
  logic [SUM_W-1:0] left_sum;
  logic [SUM_W-1:0] right_sum;

  assign left_sum  = SUM_W'(win[0]) + SUM_W'(win[1]) + SUM_W'(win[2])
                   + SUM_W'(win[3]) + SUM_W'(win[4]) + SUM_W'(win[5]);
  assign right_sum = SUM_W'(top) + SUM_W'(mid) + SUM_W'(px);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (shift_en) begin
      win[3] <= win[0];
      win[4] <= win[1];
      win[5] <= win[2];
      win[0] <= top;
      win[1] <= mid;
      win[2] <= px;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      sum_q <= left_sum + right_sum;
      col_q <= col;
      pos_q <= pos;
    end
  end

endmodule

// ===== design/bf33_div9.sv =====
// Divide-by-nine through a reciprocal multiply, feeding the result register.
// Depends on bf33_pkg.
`timescale 1ns / 1ps

module bf33_div9 #(
  parameter int COL_W = $clog2(bf33_pkg::MAX_WIDTH_DEF)
) (
  input  logic                        clk,
  input  logic                        load,
  input  logic [bf33_pkg::SUM_W-1:0]  sum,
  input  logic [COL_W-1:0]            col,
  input  bf33_pkg::pos_t              pos,
  output logic [bf33_pkg::PIX_W-1:0]  mean_value,
  output logic [COL_W-1:0]            centre_column,
  output logic [bf33_pkg::ROW_W-1:0]  centre_row,
  output logic                        frame_last
);
  import bf33_pkg::*;

  logic [SUM_W+RECIP_W-1:0] prod;

  // Exact floor for every sum up to 2295.
  assign prod = (SUM_W+RECIP_W)'(sum) * (SUM_W+RECIP_W)'(RECIP9);

  always_ff @(posedge clk) begin
    if (load) begin
      mean_value    <= prod[RECIP_SHIFT +: PIX_W];
      centre_column <= col - COL_W'(1);
      centre_row    <= pos.row - ROW_W'(1);
      frame_last    <= pos.last;
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for box_filter_3x3_mean: directed and random pixel frames
// are streamed in, each transfer is scored against an in-bench 3x3 mean predictor.
// Depends on bf33_pkg and box_filter_3x3_mean.
`timescale 1ns / 1ps

module tb;
  import bf33_pkg::*;

  localparam int COL_BITS  = 10;
  localparam int TDATA_BITS = 32;
  localparam int SETTLE    = 8;

  typedef struct {
    logic [PIX_W-1:0]    mean;
    logic [COL_BITS-1:0] col;
    logic [ROW_W-1:0]    row;
    logic                last;
  } mean_result_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [PIX_W-1:0]      s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [TDATA_BITS-1:0] m_tdata;
  logic                  m_tlast;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_data;

  // Predictor state.
  logic [PIX_W-1:0]        upper_row [1024];
  logic [PIX_W-1:0]        middle_row [1024];
  logic [PIX_W-1:0]        win [6];
  int                      col_pos;
  int                      row_pos;
  logic [WIDTH_REG_W-1:0]  width_reg;
  logic [HEIGHT_REG_W-1:0] height_reg;

  mean_result_t pending_means[$];
  int           mismatches;
  int           pixels_sent;
  bit           tx_idle_on;
  bit           rx_idle_on;
  int           rx_hold_len;

  box_filter_3x3_mean DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic int eff_width(logic [WIDTH_REG_W-1:0] v);
    if (v < 3) return 3;
    if (v > 1024) return 1024;
    return int'(v);
  endfunction

  function automatic int eff_height(logic [HEIGHT_REG_W-1:0] v);
    if (v < 3) return 3;
    if (v > MAX_HEIGHT) return MAX_HEIGHT;
    return int'(v);
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0:       return 8'hFF;
      1:       return 8'h00;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  task automatic predict_mean(input logic [PIX_W-1:0] px);
    int           w;
    int           h;
    int           c;
    int           r;
    int           sum;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    mean_result_t res;
    w = eff_width(width_reg);
    h = eff_height(height_reg);
    c = col_pos;
    r = row_pos;
    if (c >= w) c = 0;
    if (r >= h) r = 0;
    top = upper_row[c];
    mid = middle_row[c];
    if (c >= 2 && r >= 2) begin
      sum = int'(win[0]) + int'(win[1]) + int'(win[2]) + int'(win[3]) + int'(win[4])
          + int'(win[5]) + int'(top) + int'(mid) + int'(px);
      res.mean = PIX_W'(sum / 9);
      res.col  = COL_BITS'(c - 1);
      res.row  = ROW_W'(r - 1);
      res.last = (c == w - 1) && (r == h - 1);
      pending_means.push_back(res);
    end
    upper_row[c]  = mid;
    middle_row[c] = px;
    win[3] = win[0];
    win[4] = win[1];
    win[5] = win[2];
    win[0] = top;
    win[1] = mid;
    win[2] = px;
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] px);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata  = px;
    do @(posedge clk); while (!s_tready);
    predict_mean(px);
    pixels_sent++;
  endtask

  task automatic send_random_pixels(input int count);
    repeat (count) send_pixel(rand_pixel());
  endtask

  // Stop offering pixels and wait until every predicted mean has been seen.
  task automatic quiesce();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_size_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
    quiesce();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_FRAME_WIDTH) width_reg = value[WIDTH_REG_W-1:0];
    else height_reg = value;
    col_pos = 0;
    row_pos = 0;
  endtask

  task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    write_size_reg(REG_FRAME_WIDTH, w);
    write_size_reg(REG_FRAME_HEIGHT, h);
  endtask

  task automatic check_result();
    mean_result_t want;
    logic [PIX_W-1:0]    got_mean;
    logic [COL_BITS-1:0] got_col;
    logic [ROW_W-1:0]    got_row;
    got_mean = m_tdata[PIX_W-1:0];
    got_col  = m_tdata[PIX_W +: COL_BITS];
    got_row  = m_tdata[PIX_W + COL_BITS +: ROW_W];
    if (pending_means.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("tb: unexpected transfer mean=%0d col=%0d row=%0d last=%0b",
                 got_mean, got_col, got_row, m_tlast);
      return;
    end
    want = pending_means.pop_front();
    if (got_mean !== want.mean || got_col !== want.col || got_row !== want.row ||
        m_tlast !== want.last) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"tb: mismatch exp mean=%0d col=%0d row=%0d last=%0b, ",
                  "got mean=%0d col=%0d row=%0d last=%0b"},
                 want.mean, want.col, want.row, want.last,
                 got_mean, got_col, got_row, m_tlast);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_result();
  end

  initial begin
    int n;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (rx_hold_len > 0) begin
        m_tready = 1'b0;
        repeat (rx_hold_len) @(negedge clk);
        rx_hold_len = 0;
      end
      n = rx_idle_on ? $urandom_range(0, 4) : 0;
      if (n > 0) begin
        m_tready = 1'b0;
        repeat (n) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid && rx_hold_len == 0);
    end
  end

  task automatic test_default_size();
    send_random_pixels(2 * 512 + 6);
  endtask

  task automatic test_smallest_frame();
    set_frame(3, 3);
    repeat (9) send_pixel(8'hFF);
    repeat (9) send_pixel(8'h00);
    for (int i = 0; i < 9; i++) send_pixel((i % 2) ? 8'hFF : 8'h00);
    for (int i = 0; i < 9; i++) send_pixel(PIX_W'(8'hFE - i));
  endtask

  task automatic test_size_clamp();
    set_frame(0, 1);
    send_random_pixels(9);
    set_frame(2, 2);
    send_random_pixels(12);
    set_frame(1024, 3);
    send_random_pixels(20);
  endtask

  task automatic test_widest_frame();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    set_frame(2047, 3);
    send_random_pixels(20);
  endtask

  task automatic test_tallest_frame();
    set_frame(3, 8191);
    send_random_pixels(20);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_restart();
    set_frame(6, 5);
    send_random_pixels(20);
    quiesce();
    send_random_pixels(3);
    write_size_reg(REG_FRAME_HEIGHT, 5);
    send_random_pixels(2 * 30);
  endtask

  task automatic test_output_stall();
    set_frame(40, 6);
    tx_idle_on  = 1'b0;
    rx_hold_len = 300;
    send_random_pixels(240);
    tx_idle_on = 1'b1;
  endtask

  task automatic test_random_frames();
    int start;
    int w;
    int h;
    int count;
    start = pixels_sent;
    while (pixels_sent - start < 60) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1))
          write_size_reg(REG_FRAME_WIDTH, CFG_W'($urandom));
        else
          write_size_reg(REG_FRAME_HEIGHT, CFG_W'($urandom));
        send_random_pixels($urandom_range(1, 40));
      end else begin
        set_frame(CFG_W'($urandom_range(0, 16)), CFG_W'($urandom_range(0, 8)));
        w = eff_width(width_reg);
        h = eff_height(height_reg);
        count = $urandom_range(1, 2) * w * h;
        if ($urandom_range(0, 4) == 0) count = $urandom_range(1, count);
        if ($urandom_range(0, 4) == 0) begin
          send_random_pixels(count / 2);
          quiesce();
          send_random_pixels(count - count / 2);
        end else begin
          send_random_pixels(count);
        end
      end
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  initial begin
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    cfg_we     = 1'b0;
    cfg_index  = REG_FRAME_WIDTH;
    cfg_data   = '0;
    mismatches = 0;
    pixels_sent = 0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    rx_hold_len = 0;
    for (int i = 0; i < 1024; i++) begin
      upper_row[i]  = '0;
      middle_row[i] = '0;
    end
    for (int i = 0; i < 6; i++) win[i] = '0;
    col_pos    = 0;
    row_pos    = 0;
    width_reg  = WIDTH_RESET;
    height_reg = HEIGHT_RESET;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_default_size();
    test_smallest_frame();
    test_size_clamp();
    test_restart();
    test_output_stall();
    test_widest_frame();
    test_tallest_frame();
    test_random_frames();

    quiesce();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_means.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
